[design/dstq_pkg.sv]
// Shared types and constants of the deadline-sorted timer queue.
`default_nettype none

package dstq_pkg;

  localparam int DEF_ENTRIES = 16;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  entry_id;
    logic [31:0] delay_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        earlier_event;
    logic [30:0] remaining_ms;
    logic        head_valid;
    logic [3:0]  head_entry;
  } out_item_t;

  typedef struct packed {
    logic tim_we;
    logic link_we;
  } store_ctl_t;

endpackage

`default_nettype wire

[design/dstq_alu.sv]
// Shared 32-bit adder/subtractor with a deadline compare on its result.
`default_nettype none

module dstq_alu (
  input  dstq_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  logic [31:0]       ref_val,
  output logic [31:0]       sum,
  output logic              below
);
  import dstq_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: sum = a + b;
      ALU_SUB: sum = a - b;
      default: sum = a + b;
    endcase
  end

  // True when the reference deadline is strictly earlier than the result.
  assign below = ref_val < sum;

endmodule

`default_nettype wire

[design/dstq_store.sv]
// Entry memories: start and delay stamps, and next links, with registered reads.
`default_nettype none

module dstq_store #(
  parameter int ENTRIES = dstq_pkg::DEF_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dstq_pkg::store_ctl_t ctl,
  input  logic [IW-1:0]        rd_addr,
  output logic [31:0]          rd_start,
  output logic [31:0]          rd_delay,
  output logic [IW-1:0]        rd_link,
  input  logic [IW-1:0]        tim_waddr,
  input  logic [31:0]          wr_start,
  input  logic [31:0]          wr_delay,
  input  logic [IW-1:0]        link_waddr,
  input  logic [IW-1:0]        link_wdata
);
  import dstq_pkg::*;

  logic [63:0]         tim_mem [ENTRIES];
  logic [IW-1:0]       link_mem [ENTRIES];
  logic [ENTRIES-1:0]  stamped;
  logic [63:0]         tim_rd;
  logic                stamped_rd;

  // An entry that was never stamped reads as zero start and zero delay.
  always_ff @(posedge clk) begin
    if (rst) begin
      stamped <= '0;
    end else if (ctl.tim_we) begin
      stamped[tim_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tim_we) begin
      tim_mem[tim_waddr] <= {wr_start, wr_delay};
    end
    tim_rd     <= tim_mem[rd_addr];
    stamped_rd <= stamped[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[rd_addr];
  end

  assign rd_start = stamped_rd ? tim_rd[63:32] : 32'd0;
  assign rd_delay = stamped_rd ? tim_rd[31:0]  : 32'd0;

endmodule

`default_nettype wire

[design/dstq_seq.sv]
// Command sequencer: list walks for unlink and sorted insert, query arithmetic.
`default_nettype none

module dstq_seq #(
  parameter int ENTRIES = dstq_pkg::DEF_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dstq_pkg::in_item_t   in_data,
  output logic                 res_valid,
  input  logic                 res_take,
  output dstq_pkg::out_item_t  res_data,
  output dstq_pkg::store_ctl_t ctl,
  output logic [IW-1:0]        rd_addr,
  input  logic [31:0]          rd_start,
  input  logic [31:0]          rd_delay,
  input  logic [IW-1:0]        rd_link,
  output logic [IW-1:0]        tim_waddr,
  output logic [31:0]          wr_start,
  output logic [31:0]          wr_delay,
  output logic [IW-1:0]        link_waddr,
  output logic [IW-1:0]        link_wdata,
  output dstq_pkg::alu_op_t    alu_op,
  output logic [31:0]          alu_a,
  output logic [31:0]          alu_b,
  output logic [31:0]          alu_ref,
  input  logic [31:0]          alu_sum,
  input  logic                 alu_below
);
  import dstq_pkg::*;

  localparam logic [IW-1:0] LAST_STEP = IW'(ENTRIES - 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_START  = 11'b000_0000_0010,
    S_UNLINK = 11'b000_0000_0100,
    S_UWALK  = 11'b000_0000_1000,
    S_STAMP  = 11'b000_0001_0000,
    S_LWALK  = 11'b000_0010_0000,
    S_LFIN   = 11'b000_0100_0000,
    S_LFIN2  = 11'b000_1000_0000,
    S_QDIFF  = 11'b001_0000_0000,
    S_QREM   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [ENTRIES-1:0] pending;
  logic [ENTRIES-1:0] has_next;
  logic [IW-1:0]      head;
  logic               nonempty;

  logic [1:0]         cmd_q;
  logic [3:0]         id_q;
  logic [IW-1:0]      e;
  logic [31:0]        delay_q;
  logic [31:0]        now_q;
  logic [IW-1:0]      le;
  logic [IW-1:0]      ptr;
  logic [IW-1:0]      prev;
  logic [IW-1:0]      prev_link;
  logic [IW-1:0]      steps;
  logic               found;
  logic [31:0]        acc;
  logic               earlier;
  logic [30:0]        remain;
  state_t             post_state;

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign post_state = (cmd_q == CMD_CANCEL) ? S_DONE : S_STAMP;

  assign res_data.earlier_event = earlier;
  assign res_data.remaining_ms  = remain;
  assign res_data.head_valid    = nonempty;
  assign res_data.head_entry    = nonempty ? 4'(head) : 4'd0;

  // During the walks the next read address is the link that has just come back.
  always_comb begin
    rd_addr = e;
    unique case (state)
      S_UNLINK, S_STAMP: rd_addr = head;
      S_UWALK, S_LWALK:  rd_addr = rd_link;
      default:           rd_addr = e;
    endcase
  end

  always_comb begin
    ctl.tim_we  = (state == S_STAMP);
    ctl.link_we = 1'b0;
    tim_waddr   = e;
    wr_start    = now_q;
    wr_delay    = delay_q;
    link_waddr  = e;
    link_wdata  = head;
    unique case (state)
      S_UWALK: begin
        ctl.link_we = has_next[ptr] && (rd_link == e);
        link_waddr  = ptr;
        link_wdata  = le;
      end
      S_LFIN: begin
        ctl.link_we = 1'b1;
        link_waddr  = e;
        link_wdata  = found ? prev_link : head;
      end
      S_LFIN2: begin
        ctl.link_we = 1'b1;
        link_waddr  = prev;
        link_wdata  = e;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alu_op  = ALU_ADD;
    alu_a   = now_q;
    alu_b   = delay_q;
    alu_ref = acc;
    unique case (state)
      S_LWALK: begin
        alu_a = rd_start;
        alu_b = rd_delay;
      end
      S_QDIFF: begin
        alu_op = ALU_SUB;
        alu_a  = now_q;
        alu_b  = rd_start;
      end
      S_QREM: begin
        alu_op = ALU_SUB;
        alu_a  = rd_delay;
        alu_b  = acc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pending  <= '0;
      has_next <= '0;
      head     <= '0;
      nonempty <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= in_data.cmd;
            id_q    <= in_data.entry_id;
            e       <= IW'(in_data.entry_id);
            delay_q <= in_data.delay_ms;
            now_q   <= in_data.now_ms;
            state   <= S_START;
          end
        end
        S_START: begin
          earlier <= 1'b0;
          remain  <= '0;
          if (32'(id_q) >= ENTRIES) begin
            state <= S_DONE;
          end else if (cmd_q == CMD_SUBMIT || cmd_q == CMD_CANCEL) begin
            state <= S_UNLINK;
          end else if (cmd_q == CMD_QUERY) begin
            state <= S_QDIFF;
          end else begin
            state <= S_DONE;
          end
        end
        S_UNLINK: begin
          le <= rd_link;
          if (cmd_q == CMD_CANCEL) begin
            pending[e] <= 1'b0;
          end
          if (!pending[e] || !nonempty) begin
            state <= post_state;
          end else if (head == e) begin
            if (has_next[e]) begin
              head <= rd_link;
            end else begin
              nonempty <= 1'b0;
              head     <= '0;
            end
            has_next[e] <= 1'b0;
            state       <= post_state;
          end else begin
            ptr   <= head;
            steps <= '0;
            state <= S_UWALK;
          end
        end
        S_UWALK: begin
          if (!has_next[ptr]) begin
            state <= post_state;
          end else if (rd_link == e) begin
            has_next[ptr] <= has_next[e];
            has_next[e]   <= 1'b0;
            state         <= post_state;
          end else if (steps == LAST_STEP) begin
            state <= post_state;
          end else begin
            ptr   <= rd_link;
            steps <= steps + 1'b1;
          end
        end
        S_STAMP: begin
          pending[e] <= 1'b1;
          acc        <= alu_sum;
          found      <= 1'b0;
          ptr        <= head;
          steps      <= '0;
          state      <= nonempty ? S_LWALK : S_LFIN;
        end
        S_LWALK: begin
          // The new entry goes after every entry whose deadline is not later.
          if (alu_below) begin
            state <= S_LFIN;
          end else begin
            prev      <= ptr;
            prev_link <= rd_link;
            found     <= 1'b1;
            if (has_next[ptr] && steps != LAST_STEP) begin
              ptr   <= rd_link;
              steps <= steps + 1'b1;
            end else begin
              state <= S_LFIN;
            end
          end
        end
        S_LFIN: begin
          earlier <= nonempty && !found;
          if (!found) begin
            has_next[e] <= nonempty;
            head        <= e;
            nonempty    <= 1'b1;
            state       <= S_DONE;
          end else begin
            has_next[e]    <= has_next[prev];
            has_next[prev] <= 1'b1;
            state          <= S_LFIN2;
          end
        end
        S_LFIN2: begin
          state <= S_DONE;
        end
        S_QDIFF: begin
          acc   <= alu_sum;
          state <= S_QREM;
        end
        S_QREM: begin
          remain <= alu_sum[31] ? 31'd0 : alu_sum[30:0];
          state  <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/deadline_sorted_timer_queue.sv]
// Top level of the deadline-sorted timer queue: sequencer, ALU, memories, output register.
`default_nettype none

// The queue keeps ENTRIES timer entries and a linked list of the pending ones in
// deadline order, and takes one transaction at a time. A query steps through the
// start, difference and remainder states; an unused command or an entry outside
// the table goes from the start state straight to done. A cancel unlinks the
// entry, walking the list for its predecessor unless it is the head. A submit
// does the same unlink, stamps the entry, walks the list again for the sorted
// insert and writes the links, with one more link write when the entry lands
// behind another one; both walks step one linked entry per cycle through the
// single read port of the link and stamp memories. A finished result waits in
// the sequencer until the output register can take it, and the next transaction
// can be accepted in the cycle after it moves. Reset needs no clearing pass.
module deadline_sorted_timer_queue #(
  parameter int ENTRIES = dstq_pkg::DEF_ENTRIES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dstq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dstq_pkg::out_item_t out_data
);
  import dstq_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic          res_valid;
  logic          res_take;
  out_item_t     res_data;
  store_ctl_t    ctl;
  logic [IW-1:0] rd_addr;
  logic [31:0]   rd_start;
  logic [31:0]   rd_delay;
  logic [IW-1:0] rd_link;
  logic [IW-1:0] tim_waddr;
  logic [31:0]   wr_start;
  logic [31:0]   wr_delay;
  logic [IW-1:0] link_waddr;
  logic [IW-1:0] link_wdata;
  alu_op_t       alu_op;
  logic [31:0]   alu_a;
  logic [31:0]   alu_b;
  logic [31:0]   alu_ref;
  logic [31:0]   alu_sum;
  logic          alu_below;

  dstq_alu u_alu (
    .op      (alu_op),
    .a       (alu_a),
    .b       (alu_b),
    .ref_val (alu_ref),
    .sum     (alu_sum),
    .below   (alu_below)
  );

  dstq_store #(.ENTRIES(ENTRIES)) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .rd_start   (rd_start),
    .rd_delay   (rd_delay),
    .rd_link    (rd_link),
    .tim_waddr  (tim_waddr),
    .wr_start   (wr_start),
    .wr_delay   (wr_delay),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata)
  );

  dstq_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res_data   (res_data),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .rd_start   (rd_start),
    .rd_delay   (rd_delay),
    .rd_link    (rd_link),
    .tim_waddr  (tim_waddr),
    .wr_start   (wr_start),
    .wr_delay   (wr_delay),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .alu_op     (alu_op),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_ref    (alu_ref),
    .alu_sum    (alu_sum),
    .alu_below  (alu_below)
  );

  // The result moves into the output register when it is empty or being emptied.
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the deadline-sorted timer queue, with a built-in list predictor.
`timescale 1ns / 1ps

module tb_top;
  import dstq_pkg::*;

  localparam int N_TIMERS = DEF_ENTRIES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PER_PHASE = 270;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 2 * N_TIMERS + 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t res;
  } timer_cmd_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Typed-in expectation that travels with the transaction being offered.
  bit        expect_fixed;
  out_item_t fixed_result;

  // Predicted copy of the timer table and its deadline-ordered list.
  logic [31:0] tq_start [N_TIMERS];
  logic [31:0] tq_delay [N_TIMERS];
  logic        tq_pending [N_TIMERS];
  logic [3:0]  tq_next [N_TIMERS];
  logic        tq_has_next [N_TIMERS];
  logic [3:0]  tq_head;
  logic        tq_nonempty;

  out_item_t   awaited_status[$];
  int unsigned mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int unsigned hold_requests = 0;
  logic [31:0] uptime;

  deadline_sorted_timer_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] deadline(input logic [3:0] e);
    return tq_start[e] + tq_delay[e];
  endfunction

  function automatic void unlink_timer(input logic [3:0] e);
    logic [3:0] p;
    logic [3:0] n;
    if (!tq_nonempty) return;
    if (tq_head == e) begin
      if (tq_has_next[e]) begin
        tq_head = tq_next[e];
      end else begin
        tq_nonempty = 1'b0;
        tq_head = '0;
      end
      tq_has_next[e] = 1'b0;
      return;
    end
    p = tq_head;
    for (int s = 0; s < N_TIMERS; s++) begin
      if (!tq_has_next[p]) return;
      n = tq_next[p];
      if (n == e) begin
        tq_has_next[p] = tq_has_next[e];
        tq_next[p] = tq_next[e];
        tq_has_next[e] = 1'b0;
        return;
      end
      p = n;
    end
  endfunction

  // Links the entry behind the last one whose deadline is not later; returns
  // whether it now precedes the old head.
  function automatic logic insert_by_deadline(input logic [3:0] e);
    logic [31:0] dl;
    logic        found;
    logic        more;
    logic        earlier;
    logic [3:0]  prev;
    logic [3:0]  cur;
    dl = deadline(e);
    found = 1'b0;
    more = tq_nonempty;
    prev = '0;
    cur = tq_head;
    for (int s = 0; s < N_TIMERS && more; s++) begin
      if (dl < deadline(cur)) break;
      prev = cur;
      found = 1'b1;
      if (tq_has_next[cur]) cur = tq_next[cur];
      else more = 1'b0;
    end
    earlier = tq_nonempty && (dl < deadline(tq_head));
    if (!found) begin
      tq_next[e] = tq_head;
      tq_has_next[e] = tq_nonempty;
      tq_head = e;
      tq_nonempty = 1'b1;
    end else begin
      tq_next[e] = tq_next[prev];
      tq_has_next[e] = tq_has_next[prev];
      tq_next[prev] = e;
      tq_has_next[prev] = 1'b1;
    end
    return earlier;
  endfunction

  function automatic out_item_t timer_list_step(input in_item_t it);
    out_item_t   r;
    logic [31:0] left;
    logic [3:0]  e;
    r = '0;
    e = it.entry_id;
    if (it.cmd == CMD_SUBMIT) begin
      if (tq_pending[e]) unlink_timer(e);
      tq_start[e] = it.now_ms;
      tq_delay[e] = it.delay_ms;
      tq_pending[e] = 1'b1;
      r.earlier_event = insert_by_deadline(e);
    end else if (it.cmd == CMD_CANCEL) begin
      if (tq_pending[e]) unlink_timer(e);
      tq_pending[e] = 1'b0;
    end else if (it.cmd == CMD_QUERY) begin
      left = tq_delay[e] - (it.now_ms - tq_start[e]);
      r.remaining_ms = left[31] ? '0 : left[30:0];
    end
    r.head_valid = tq_nonempty;
    r.head_entry = tq_nonempty ? tq_head : '0;
    return r;
  endfunction

  function automatic timer_cmd_row_t directed_row(input logic [1:0] cmd,
      input logic [3:0] id, input logic [31:0] delay, input logic [31:0] now,
      input bit fixed, input logic ev, input logic [30:0] rem,
      input logic hv, input logic [3:0] he);
    timer_cmd_row_t row;
    row.item = '{cmd: cmd, entry_id: id, delay_ms: delay, now_ms: now};
    row.fixed = fixed;
    row.res = '{earlier_event: ev, remaining_ms: rem, head_valid: hv, head_entry: he};
    return row;
  endfunction

  // Mostly a slowly advancing clock with short delays, so that deadlines tie
  // and the list grows long; the rest exercises wrap-around and full-range bits.
  function automatic in_item_t random_request();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) it.cmd = CMD_SUBMIT;
    else if (pick < 65) it.cmd = CMD_CANCEL;
    else if (pick < 95) it.cmd = CMD_QUERY;
    else it.cmd = CMD_UNUSED;
    it.entry_id = 4'($urandom_range(N_TIMERS - 1));
    if ($urandom_range(99) < 2) uptime = $urandom();
    else uptime = uptime + $urandom_range(40);
    it.now_ms = ($urandom_range(99) < 88) ? uptime : $urandom();
    if (it.cmd != CMD_SUBMIT) begin
      it.delay_ms = $urandom();
    end else begin
      case ($urandom_range(9))
        5:       it.delay_ms = 50 * $urandom_range(2);
        6:       it.delay_ms = $urandom();
        7:       it.delay_ms = 32'hFFFF_FFFF - $urandom_range(300);
        8:       it.delay_ms = 32'h7FFF_FFF0 + $urandom_range(31);
        9:       it.delay_ms = $urandom_range(5000);
        default: it.delay_ms = $urandom_range(300);
      endcase
    end
    return it;
  endfunction

  task automatic offer(input in_item_t it, input bit fixed, input out_item_t res);
    in_valid <= 1'b1;
    in_data <= it;
    expect_fixed <= fixed;
    fixed_result <= res;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
  endtask

  // Scoreboard: predicts on every accepted command, checks every accepted status.
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t pred;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_status.size() == 0) begin
          mismatch_count++;
          $display("%0t: status expected none, got %h", $time, out_data);
        end else begin
          want = awaited_status.pop_front();
          if (out_data.earlier_event !== want.earlier_event) begin
            mismatch_count++;
            $display("%0t: earlier_event expected %0d, got %0d", $time,
                     want.earlier_event, out_data.earlier_event);
          end
          if (out_data.remaining_ms !== want.remaining_ms) begin
            mismatch_count++;
            $display("%0t: remaining_ms expected %0d, got %0d", $time,
                     want.remaining_ms, out_data.remaining_ms);
          end
          if (out_data.head_valid !== want.head_valid) begin
            mismatch_count++;
            $display("%0t: head_valid expected %0d, got %0d", $time,
                     want.head_valid, out_data.head_valid);
          end
          if (out_data.head_entry !== want.head_entry) begin
            mismatch_count++;
            $display("%0t: head_entry expected %0d, got %0d", $time,
                     want.head_entry, out_data.head_entry);
          end
        end
      end
      if (in_valid && in_ready) begin
        pred = timer_list_step(in_data);
        awaited_status.push_back(expect_fixed ? fixed_result : pred);
      end
    end
  end

  // Result sink: random back-pressure, plus one long hold-off on request.
  initial begin : sink
    int unsigned holds_served;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    timer_cmd_row_t rows[$];
    in_item_t       req;
    int unsigned    sent;

    for (int i = 0; i < N_TIMERS; i++) begin
      tq_start[i] = '0;
      tq_delay[i] = '0;
      tq_pending[i] = 1'b0;
      tq_next[i] = '0;
      tq_has_next[i] = 1'b0;
    end
    tq_head = '0;
    tq_nonempty = 1'b0;
    uptime = 32'd2000;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    expect_fixed <= 1'b0;
    fixed_result <= '0;

    // After reset, idle entries and the unused command.
    rows.push_back(directed_row(CMD_QUERY, 0, 0, 0, 1, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_QUERY, 15, 32'hFFFF_FFFF, 5, 1, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_CANCEL, 3, 7, 9, 1, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_UNUSED, 7, 1, 1, 1, 0, 0, 0, 0));
    // First submit, queries before and after the deadline, an earlier one, a tie, a cancel of the head.
    rows.push_back(directed_row(CMD_SUBMIT, 5, 100, 1000, 1, 0, 0, 1, 5));
    rows.push_back(directed_row(CMD_QUERY, 5, 0, 1000, 1, 0, 100, 1, 5));
    rows.push_back(directed_row(CMD_QUERY, 5, 0, 1200, 1, 0, 0, 1, 5));
    rows.push_back(directed_row(CMD_SUBMIT, 2, 10, 1000, 1, 1, 0, 1, 2));
    rows.push_back(directed_row(CMD_SUBMIT, 9, 10, 1000, 1, 0, 0, 1, 2));
    rows.push_back(directed_row(CMD_CANCEL, 2, 0, 1000, 1, 0, 0, 1, 9));
    rows.push_back(directed_row(CMD_QUERY, 9, 0, 1000, 1, 0, 10, 1, 9));
    // Resubmits of pending entries, wrapping deadlines and field extremes.
    rows.push_back(directed_row(CMD_SUBMIT, 5, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_SUBMIT, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_SUBMIT, 15, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_QUERY, 15, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_SUBMIT, 9, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_SUBMIT, 5, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_CANCEL, 15, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_CANCEL, 15, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_QUERY, 3, 0, 32'hAAAA_AAAA, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_UNUSED, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_CANCEL, 5, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_CANCEL, 9, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(directed_row(CMD_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 20;
    receiver_stall_pct = 20;
    foreach (rows[i]) begin
      sender_gap();
      offer(rows[i].item, rows[i].fixed, rows[i].res);
    end
    wait_for_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
      endcase
      sent = 0;
      while (sent < PER_PHASE) begin
        req = random_request();
        sender_gap();
        offer(req, 1'b0, '0);
        if (req.cmd != CMD_UNUSED) begin
          sent++;
          // Back-to-back commands against a stalled sink back up the result register and stall the sender.
          if (ph == 0 && sent == 60) hold_requests++;
        end
      end
      wait_for_results();
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[deadline_sorted_timer_queue.f]
design/dstq_pkg.sv
design/dstq_alu.sv
design/dstq_store.sv
design/dstq_seq.sv
design/deadline_sorted_timer_queue.sv
tb/tb_top.sv
